>>> rtl/olrsgd_pkg.sv
package olrsgd_pkg;

    // Field widths of the item and result channels.
    localparam int FEAT_W  = 16;
    localparam int PROB_W  = 16;
    localparam int SCORE_W = 32;
    localparam int RATE_W  = 16;

    // Step size after reset, 0.01 in Q0.16.
    localparam logic [RATE_W-1:0] RATE_RESET = 16'd655;

    // Default number of sigmoid samples.
    localparam int SIG_DEPTH_DEFAULT = 256;

    // Score window of the sigmoid table in Q16.16: [-8, 8).
    localparam longint SCORE_LO = -64'sd524288;
    localparam longint SCORE_HI = 64'sd524287;

    // Exponential constants in Q2.30.
    localparam longint Q30_ONE    = 64'sd1073741824;
    localparam longint Q30_HALF   = 64'sd536870912;
    localparam longint Q30_EXP_M1 = 64'sd395007542;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_SCORE,
        ST_INDEX,
        ST_LOOKUP,
        ST_INTERP,
        ST_PROB,
        ST_RATE_ERR,
        ST_STEP_A,
        ST_STEP_B,
        ST_STEP_W2
    } state_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_A,
        OP_MUL_B,
        OP_SCORE,
        OP_INDEX,
        OP_LOOKUP,
        OP_INTERP,
        OP_PROB,
        OP_RATE_ERR,
        OP_STEP_A,
        OP_STEP_B,
        OP_STEP_W2
    } dp_op_t;

    // Status returned by the datapath.
    typedef struct packed {
        logic train;
        logic out_full;
    } dp_stat_t;

    // Unsigned long division by shift and subtract, used only while elaborating the table.
    function automatic longint udiv(input longint num, input longint den);
        logic [63:0] n_u;
        logic [63:0] d_u;
        logic [63:0] q;
        logic [63:0] r;
        n_u = num;
        d_u = den;
        q   = '0;
        r   = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n_u[b]};
            if (r >= d_u)
            begin
                r    = r - d_u;
                q[b] = 1'b1;
            end
        end
        return longint'(q);
    endfunction

    // e^-a in Q2.30 for a in Q16.16 between 0 and 8.0.
    function automatic longint exp_neg(input longint a);
        longint n;
        longint f;
        longint e;
        longint term;
        longint sum;
        n    = a >>> 16;
        f    = a & 64'sd65535;
        e    = Q30_ONE;
        term = Q30_ONE;
        sum  = Q30_ONE;
        // Whole part: repeated multiplication by e^-1 with rounding.
        for (int k = 0; k < 8; k++)
        begin
            if (longint'(k) < n)
            begin
                e = (e * Q30_EXP_M1 + Q30_HALF) >>> 30;
            end
        end
        // Fractional part: twelve terms of the alternating series.
        for (int k = 1; k <= 12; k++)
        begin
            term = udiv((term * f) >>> 16, longint'(k));
            if (k[0])
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        return (e * sum) >>> 30;
    endfunction

    // Sigmoid of x (Q16.16) in Q0.16, rounded and held below full scale.
    function automatic logic [PROB_W-1:0] sigmoid_sample(input longint x);
        longint ax;
        longint e;
        longint den;
        longint num;
        longint p;
        ax  = (x < 0) ? -x : x;
        e   = exp_neg(ax);
        den = Q30_ONE + e;
        num = (x >= 0) ? (64'sd1 <<< 46) : (e <<< 16);
        p   = udiv(num + (den >>> 1), den);
        if (p > 64'sd65535)
        begin
            p = 64'sd65535;
        end
        return p[PROB_W-1:0];
    endfunction

    // Score at which table entry i is sampled.
    function automatic longint table_x(input longint i, input longint depth);
        return SCORE_LO + udiv(i <<< 20, depth);
    endfunction

endpackage

>>> rtl/olrsgd_sample_if.sv
interface olrsgd_sample_if;
    import olrsgd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     func;
    logic signed [FEAT_W-1:0] feature_a;
    logic signed [FEAT_W-1:0] feature_b;
    logic                     label;

    modport source (output valid, func, feature_a, feature_b, label, input ready);
    modport sink   (input valid, func, feature_a, feature_b, label, output ready);
endinterface

>>> rtl/olrsgd_result_if.sv
interface olrsgd_result_if;
    import olrsgd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [PROB_W-1:0]         probability;
    logic signed [SCORE_W-1:0] raw_score;

    modport source (output valid, probability, raw_score, input ready);
    modport sink   (input valid, probability, raw_score, output ready);
endinterface

>>> rtl/olrsgd_ctrl.sv
module olrsgd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  olrsgd_pkg::dp_stat_t  stat,
    output olrsgd_pkg::dp_op_t    op
);
    import olrsgd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: one fixed sequence per item, with the training steps only in train mode.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_MUL_A;
            ST_MUL_A:    state_next = ST_MUL_B;
            ST_MUL_B:    state_next = ST_SCORE;
            ST_SCORE:    state_next = ST_INDEX;
            ST_INDEX:    state_next = ST_LOOKUP;
            ST_LOOKUP:   state_next = ST_INTERP;
            ST_INTERP:   state_next = ST_PROB;
            ST_PROB:
            begin
                if (!stat.out_full)
                begin
                    state_next = stat.train ? ST_RATE_ERR : ST_IDLE;
                end
            end
            ST_RATE_ERR: state_next = ST_STEP_A;
            ST_STEP_A:   state_next = ST_STEP_B;
            ST_STEP_B:   state_next = ST_STEP_W2;
            ST_STEP_W2:  state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs: the datapath operation for the current state.
    always_comb
    begin
        in_ready = 1'b0;
        op       = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) op = OP_LOAD;
            end
            ST_MUL_A:    op = OP_MUL_A;
            ST_MUL_B:    op = OP_MUL_B;
            ST_SCORE:    op = OP_SCORE;
            ST_INDEX:    op = OP_INDEX;
            ST_LOOKUP:   op = OP_LOOKUP;
            ST_INTERP:   op = OP_INTERP;
            ST_PROB:     if (!stat.out_full) op = OP_PROB;
            ST_RATE_ERR: op = OP_RATE_ERR;
            ST_STEP_A:   op = OP_STEP_A;
            ST_STEP_B:   op = OP_STEP_B;
            ST_STEP_W2:  op = OP_STEP_W2;
            default:     op = OP_NONE;
        endcase
    end

`ifndef ASSERT_OFF
    // An accepted item starts the score multiply at once.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> state_reg == ST_MUL_A)
        else $error("accepted item did not start the score");

    // A result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_PROB) |-> !stat.out_full)
        else $error("result written while output register full");

    // A train item goes on to the update after its result.
    a_train_updates: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_PROB && stat.train) |=> state_reg == ST_RATE_ERR)
        else $error("train item skipped the update");
`endif

endmodule

>>> rtl/olrsgd_datapath.sv
module olrsgd_datapath #(
    parameter int SIG_DEPTH = olrsgd_pkg::SIG_DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  olrsgd_pkg::dp_op_t                    op,
    output olrsgd_pkg::dp_stat_t                  stat,
    input  logic                                  cfg_wr_en,
    input  logic [olrsgd_pkg::RATE_W-1:0]         cfg_wr_data,
    input  logic                                  in_func,
    input  logic signed [olrsgd_pkg::FEAT_W-1:0]  in_feature_a,
    input  logic signed [olrsgd_pkg::FEAT_W-1:0]  in_feature_b,
    input  logic                                  in_label,
    olrsgd_result_if.source                       result
);
    import olrsgd_pkg::*;

    localparam int IDXW  = $clog2(SIG_DEPTH);
    localparam int POS_W = 20 + IDXW;

    localparam logic signed [SCORE_W-1:0] LO32 = -32'sd524288;
    localparam logic signed [SCORE_W-1:0] HI32 = 32'sd524287;

    // Saturate a wide sum to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < -38'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Sigmoid samples, computed while elaborating.
    logic [PROB_W-1:0] sig_rom [SIG_DEPTH];

    for (genvar gi = 0; gi < SIG_DEPTH; gi++)
    begin : g_rom
        localparam logic [PROB_W-1:0] SAMPLE =
            sigmoid_sample(table_x(longint'(gi), longint'(SIG_DEPTH)));
        assign sig_rom[gi] = SAMPLE;
    end

    // Model state.
    logic signed [SCORE_W-1:0] w1_reg;
    logic signed [SCORE_W-1:0] w2_reg;
    logic signed [SCORE_W-1:0] bias_reg;
    logic [RATE_W-1:0]         rate_reg;

    // Item and working registers.
    logic signed [FEAT_W-1:0]  fa_reg;
    logic signed [FEAT_W-1:0]  fb_reg;
    logic                      label_reg;
    logic                      func_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [47:0]        acc_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic [IDXW-1:0]           idx_reg;
    logic [19:0]               frac_reg;
    logic [PROB_W-1:0]         lo_reg;
    logic signed [16:0]        diff_reg;
    logic [PROB_W-1:0]         prob_reg;
    logic signed [MUL_A_W-1:0] re_reg;

    // Output register.
    logic                      out_valid_reg;
    logic [PROB_W-1:0]         out_prob_reg;
    logic signed [SCORE_W-1:0] out_score_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  product;
    logic signed [48:0]        sum_ab;
    logic signed [37:0]        score_wide;
    logic [19:0]               offset;
    logic [POS_W-1:0]          pos;
    logic [IDXW-1:0]           idx_nxt;
    logic [PROB_W-1:0]         hi_val;
    logic [16:0]               prob_wide;
    logic signed [MUL_B_W-1:0] err;
    logic signed [37:0]        bias_wide;
    logic signed [37:0]        w1_wide;
    logic signed [37:0]        w2_wide;

    // Operand selection for the one shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_MUL_A:
            begin
                mul_a = {{2{w1_reg[31]}}, w1_reg};
                mul_b = {{2{fa_reg[15]}}, fa_reg};
            end
            OP_MUL_B:
            begin
                mul_a = {{2{w2_reg[31]}}, w2_reg};
                mul_b = {{2{fb_reg[15]}}, fb_reg};
            end
            OP_INTERP:
            begin
                mul_a = {14'd0, frac_reg};
                mul_b = {diff_reg[16], diff_reg};
            end
            OP_RATE_ERR:
            begin
                mul_a = {18'd0, rate_reg};
                mul_b = err;
            end
            OP_STEP_A:
            begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = {{2{fa_reg[15]}}, fa_reg};
            end
            OP_STEP_B:
            begin
                mul_a = re_reg;
                mul_b = {{2{fb_reg[15]}}, fb_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // Score: the two products summed, floored to Q16.16, plus the bias.
    assign sum_ab     = {acc_reg[47], acc_reg} + {prod_reg[47], prod_reg[47:0]};
    assign score_wide = {sum_ab[48], sum_ab[48:12]} + {{6{bias_reg[31]}}, bias_reg};

    // Table position of the clamped score.
    always_comb
    begin
        if (score_reg < LO32)
        begin
            offset = '0;
        end
        else if (score_reg > HI32)
        begin
            offset = '1;
        end
        else
        begin
            offset = score_reg[19:0] + 20'h80000;
        end
    end

    assign pos = {{IDXW{1'b0}}, offset} * POS_W'(SIG_DEPTH);

    // Upper neighbor of the bin; the top bin rises to full scale.
    assign idx_nxt = (idx_reg == IDXW'(SIG_DEPTH - 1)) ? '0 : idx_reg + 1'b1;
    assign hi_val  = (idx_reg == IDXW'(SIG_DEPTH - 1)) ? {PROB_W{1'b1}} : sig_rom[idx_nxt];

    // Interpolated prediction and its error against the label.
    assign prob_wide = {1'b0, lo_reg} + prod_reg[36:20];
    assign err       = (label_reg ? 18'h10000 : 18'h00000) - {2'b00, prob_reg};

    // Saturating updates of bias and weights.
    assign bias_wide = {{6{bias_reg[31]}}, bias_reg} + {{20{prod_reg[33]}}, prod_reg[33:16]};
    assign w1_wide   = {{6{w1_reg[31]}}, w1_reg} + {{14{prod_reg[51]}}, prod_reg[51:28]};
    assign w2_wide   = {{6{w2_reg[31]}}, w2_reg} + {{14{prod_reg[51]}}, prod_reg[51:28]};

    // Model state and step size.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_reg   <= '0;
            w2_reg   <= '0;
            bias_reg <= '0;
            rate_reg <= RATE_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                rate_reg <= cfg_wr_data;
            end
            if (op == OP_STEP_A)
            begin
                bias_reg <= sat32(bias_wide);
            end
            if (op == OP_STEP_B)
            begin
                w1_reg <= sat32(w1_wide);
            end
            if (op == OP_STEP_W2)
            begin
                w2_reg <= sat32(w2_wide);
            end
        end
    end

    // Working registers, loaded by the operation in progress.
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                fa_reg    <= in_feature_a;
                fb_reg    <= in_feature_b;
                label_reg <= in_label;
                func_reg  <= in_func;
            end
            OP_MUL_A:
            begin
                prod_reg <= product;
            end
            OP_MUL_B:
            begin
                acc_reg  <= prod_reg[47:0];
                prod_reg <= product;
            end
            OP_SCORE:
            begin
                score_reg <= sat32(score_wide);
            end
            OP_INDEX:
            begin
                idx_reg  <= pos[POS_W-1:20];
                frac_reg <= pos[19:0];
            end
            OP_LOOKUP:
            begin
                lo_reg   <= sig_rom[idx_reg];
                diff_reg <= {1'b0, hi_val} - {1'b0, sig_rom[idx_reg]};
            end
            OP_INTERP:
            begin
                prod_reg <= product;
            end
            OP_PROB:
            begin
                prob_reg <= prob_wide[PROB_W-1:0];
            end
            OP_RATE_ERR:
            begin
                prod_reg <= product;
            end
            OP_STEP_A:
            begin
                re_reg   <= prod_reg[MUL_A_W-1:0];
                prod_reg <= product;
            end
            OP_STEP_B:
            begin
                prod_reg <= product;
            end
            default:
            begin
            end
        endcase
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (op == OP_PROB)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (op == OP_PROB)
        begin
            out_prob_reg  <= prob_wide[PROB_W-1:0];
            out_score_reg <= score_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.probability = out_prob_reg;
    assign result.raw_score   = out_score_reg;

    assign stat.train    = func_reg;
    assign stat.out_full = out_valid_reg && !result.ready;

`ifndef ASSERT_OFF
    // The first weight moves only in its own update step.
    a_w1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (op != OP_STEP_B) |=> $stable(w1_reg))
        else $error("first weight changed outside its update");

    // The bias moves only in its own update step.
    a_bias_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (op != OP_STEP_A) |=> $stable(bias_reg))
        else $error("bias changed outside its update");

    // Writing the result always presents it.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_PROB) |=> out_valid_reg)
        else $error("written result not presented");
`endif

endmodule

>>> rtl/online_logistic_regression_sgd.sv
// Channel   Modport  Item contents
// --------  -------  ------------------------------------------------
// sample    sink     func, feature_a, feature_b, label
// result    source   probability, raw_score
// cfg_wr_*  -        step size write, no read-back
//
// Each item runs the multiply, score, index, lookup and interpolation states and the result
// state that registers the result; a train item then runs the update states. One shared
// 34x18 multiplier serves the two score products, the interpolation and the three update
// products in sequence. Reset clears the weights and bias and loads the step size 655; the
// sigmoid table is constant. A result that is not taken holds in the output register; the
// next result waits for it, while the training steps of the current item go on.
module online_logistic_regression_sgd #(
    parameter int SIGMOID_TABLE_DEPTH = olrsgd_pkg::SIG_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    olrsgd_sample_if.sink                 sample,
    olrsgd_result_if.source               result,
    input  logic                          cfg_wr_en,
    input  logic [olrsgd_pkg::RATE_W-1:0] cfg_wr_data
);
    import olrsgd_pkg::*;

    dp_op_t   op;
    dp_stat_t stat;
    logic     sample_ready;

    assign sample.ready = sample_ready;

    // Sequencer for one item at a time.
    olrsgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample_ready),
        .stat     (stat),
        .op       (op)
    );

    // Score, sigmoid lookup and weight update.
    olrsgd_datapath #(
        .SIG_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .stat         (stat),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_func      (sample.func),
        .in_feature_a (sample.feature_a),
        .in_feature_b (sample.feature_b),
        .in_label     (sample.label),
        .result       (result)
    );

endmodule
